/* sv/hca_pkg.sv */
`timescale 1ns / 1ps

package hca_pkg;

  // Fixed-point scales: hue in degrees with 7 fraction bits, S and L in Q2.14
  localparam int HUE_FULL  = 46080;
  localparam int HUE_THIRD = 15360;
  localparam int HUE_SIXTH = 7680;
  localparam int HUE_FALL_END = 4 * HUE_SIXTH;
  localparam int HUE_HIGH_END = 3 * HUE_SIXTH;
  localparam int Q_ONE     = 16384;
  localparam int Q_HALF    = Q_ONE / 2;

  // Neutral settings and fixed divisors
  localparam int HUE_NEUTRAL   = 180;
  localparam int SCALE_NEUTRAL = 100;
  localparam int LIGHT_DIV     = 510;
  localparam int BYTE_MAX      = 255;

  // Reciprocals for the constant divisions: x / d = (x * RECIP) >> SHIFT over the used range.
  // Lightness: (64*sum + 255) / 510, operand below 32896
  localparam int LIGHT_RECIP  = 32897;
  localparam int LIGHT_SHIFT  = 24;
  // Percentage scaling: operand below 2^22
  localparam int PCT_RECIP    = 5368710;
  localparam int PCT_SHIFT    = 29;
  // Interpolation by fifteen: operand below 2^23
  localparam int INTERP_RECIP = 8947849;
  localparam int INTERP_SHIFT = 27;
  // Bias that lifts the signed interpolation value above zero before dividing
  localparam int INTERP_BIAS   = 262144;
  localparam int INTERP_OFFSET = 15 * INTERP_BIAS;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_HUE_SHIFT   = 2'd0,
    REG_SAT_SCALE   = 2'd1,
    REG_LIGHT_SCALE = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [8:0] hue_shift;
    logic [7:0] sat_scale;
    logic [7:0] light_scale;
  } cfg_t;

  // Segment of the hue circle a channel falls in
  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_t;

  typedef struct packed {
    seg_t        seg;
    logic [12:0] w;
  } chan_w_t;

  // Classify a channel hue and give the interpolation weight
  function automatic chan_w_t chan_weight(input logic [15:0] t);
    chan_w_t res;
    logic [15:0] fall_w;
    fall_w = 16'(HUE_FALL_END) - t;
    if (t < 16'(HUE_SIXTH)) begin
      res.seg = SEG_RISE;
      res.w   = t[12:0];
    end else if (t < 16'(HUE_HIGH_END)) begin
      res.seg = SEG_HIGH;
      res.w   = '0;
    end else if (t < 16'(HUE_FALL_END)) begin
      res.seg = SEG_FALL;
      res.w   = fall_w[12:0];
    end else begin
      res.seg = SEG_LOW;
      res.w   = '0;
    end
    return res;
  endfunction

endpackage

/* sv/hca_div_pipe.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per register stage, several lanes abreast
module hca_div_pipe #(
  parameter int LANES = 3,
  parameter int NW    = 24,
  parameter int DW    = 9,
  parameter int QW    = 16,
  parameter int SW    = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_vld,
  input  logic [LANES-1:0][NW-1:0]     num,
  input  logic [LANES-1:0][DW-1:0]     dvs,
  input  logic [SW-1:0]                side_in,
  output logic                         out_vld,
  output logic [LANES-1:0][QW-1:0]     quo,
  output logic [LANES-1:0][NW-1:0]     rem,
  output logic [SW-1:0]                side_out
);

  localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [QW:0]                 vld;
  logic [LANES-1:0][NW-1:0]    rem_s  [QW+1];
  logic [LANES-1:0][QW-1:0]    quo_s  [QW+1];
  logic [LANES-1:0][DW-1:0]    dv_s   [QW+1];
  logic [SW-1:0]               side_s [QW+1];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[QW-1:0], in_vld};
    end
  end

  // Load the first stage
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_s[0]  <= num;
      quo_s[0]  <= '0;
      dv_s[0]   <= dvs;
      side_s[0] <= side_in;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [LANES-1:0][NW-1:0] rem_n;
    logic [LANES-1:0][QW-1:0] quo_n;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [CW-1:0] dsh;
      logic [CW-1:0] rext;
      logic [CW-1:0] diff;
      logic          take;
      assign dsh  = CW'(dv_s[k][l]) << B;
      assign rext = CW'(rem_s[k][l]);
      assign take = rext >= dsh;
      assign diff = rext - dsh;
      assign rem_n[l] = take ? diff[NW-1:0] : rem_s[k][l];
      assign quo_n[l] = quo_s[k][l] | (QW'(take) << B);
    end

    // Try one quotient bit, keep the partial remainder
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_s[k+1]  <= rem_n;
        quo_s[k+1]  <= quo_n;
        dv_s[k+1]   <= dv_s[k];
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign out_vld  = vld[QW];
  assign quo      = quo_s[QW];
  assign rem      = rem_s[QW];
  assign side_out = side_s[QW];

endmodule

/* sv/hca_cfg_regs.sv */
`timescale 1ns / 1ps

module hca_cfg_regs
  import hca_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data,
  output cfg_t       cfg,
  output logic       neutral
);

  assign cfg_ready = 1'b1;

  // Write one register per beat; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hue_shift   <= 9'(HUE_NEUTRAL);
      cfg.sat_scale   <= 8'(SCALE_NEUTRAL);
      cfg.light_scale <= 8'(SCALE_NEUTRAL);
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_HUE_SHIFT:   cfg.hue_shift   <= cfg_data;
        REG_SAT_SCALE:   cfg.sat_scale   <= cfg_data[7:0];
        REG_LIGHT_SCALE: cfg.light_scale <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign neutral = (cfg.hue_shift == 9'(HUE_NEUTRAL)) &&
                   (cfg.sat_scale == 8'(SCALE_NEUTRAL)) &&
                   (cfg.light_scale == 8'(SCALE_NEUTRAL));

endmodule

/* sv/hsl_color_adjust.sv */
`timescale 1ns / 1ps
// HSL colour adjuster, fully pipelined.
// Pipeline: a bit-per-stage divider of 17 stages for S and H plus eight
// register stages.
// Throughput: one pixel per cycle; a stall at the output holds every stage.
// Reset (rst, synchronous): clears all valid bits, config returns to 180/100/100.
module hsl_color_adjust
  import hca_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] pixel_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] pixel_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  cfg_t cfg;
  logic neutral;
  logic adv;

  hca_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .neutral   (neutral)
  );

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---------------- input stage ----------------
  logic        a_vld;
  logic [31:0] a_px;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_px <= pixel_in;
    end
  end

  // Min, max, L and the numerators for S and H
  logic [7:0]  ar, ag, ab, amn, amx, ad;
  logic [8:0]  asum, aden;
  logic [11:0] ahb;
  logic [15:0] l_fnum, al;
  logic [31:0] l_fq;
  logic [1:0][23:0] d1_num;
  logic [1:0][8:0]  d1_dvs;

  always_comb begin
    ar = a_px[7:0];
    ag = a_px[15:8];
    ab = a_px[23:16];
    amn = (ar < ag) ? ar : ag;
    if (ab < amn) amn = ab;
    amx = (ar > ag) ? ar : ag;
    if (ab > amx) amx = ab;
    ad   = amx - amn;
    asum = 9'(amx) + 9'(amn);
    aden = (asum <= 9'(BYTE_MAX)) ? asum : 9'(LIGHT_DIV) - asum;
    if (ar == amn) begin
      ahb = 12'(ad) * 12'd3 + 12'(ab) - 12'(ag);
    end else if (ag == amn) begin
      ahb = 12'(ad) * 12'd5 + 12'(ar) - 12'(ab);
    end else begin
      ahb = 12'(ad) + 12'(ag) - 12'(ar);
    end
    // L = 32*sum + (64*sum + 255) / 510
    l_fnum = {1'b0, asum, 6'b0} + 16'd255;
    l_fq   = 32'(l_fnum) * 32'(LIGHT_RECIP);
    al     = {2'b0, asum, 5'b0} + 16'(l_fq[LIGHT_SHIFT +: 8]);
    if (ad == 8'd0) begin
      d1_num[0] = '0;
      d1_dvs[0] = 9'd1;
      d1_num[1] = '0;
      d1_dvs[1] = 9'd1;
    end else begin
      d1_num[0] = {2'b0, ad, 14'b0} + 24'(aden >> 1);
      d1_dvs[0] = aden;
      d1_num[1] = 24'(ahb) * 24'(HUE_SIXTH) + 24'(ad >> 1);
      d1_dvs[1] = {1'b0, ad};
    end
  end

  // ---------------- divider: S, H ----------------
  logic             d1_vld;
  logic [1:0][15:0] d1_quo;
  logic [1:0][23:0] d1_rem;
  logic [47:0]      d1_side;
  logic [31:0]      d1_px;
  logic [15:0]      d1_l;

  hca_div_pipe #(.LANES(2), .NW(24), .DW(9), .QW(16), .SW(48)) u_div_hsl (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (a_vld),
    .num      (d1_num),
    .dvs      (d1_dvs),
    .side_in  ({a_px, al}),
    .out_vld  (d1_vld),
    .quo      (d1_quo),
    .rem      (d1_rem),
    .side_out (d1_side)
  );

  assign d1_px = d1_side[47:16];
  assign d1_l  = d1_side[15:0];

  // Shift and wrap hue, form the S and L percentage products
  logic [15:0]        h1, hadj;
  logic signed [17:0] hoff, hsum;
  logic [22:0]        s_prod, l_prod;

  always_comb begin
    h1 = (d1_quo[1] >= 16'(HUE_FULL)) ? d1_quo[1] - 16'(HUE_FULL) : d1_quo[1];
    hoff = $signed({9'b0, cfg.hue_shift}) - 18'sd180;
    hsum = $signed({2'b0, h1}) + (hoff <<< 7);
    if (hsum < 18'sd0) begin
      hsum = hsum + 18'sd46080;
    end else if (hsum >= 18'sd46080) begin
      hsum = hsum - 18'sd46080;
    end
    hadj = hsum[15:0];
    s_prod = 23'(d1_quo[0][14:0]) * 23'(cfg.sat_scale) + 23'd50;
    l_prod = 23'(d1_l[14:0]) * 23'(cfg.light_scale) + 23'd50;
  end

  // ---------------- scale stage: products ----------------
  logic        b_vld;
  logic [31:0] b_px;
  logic [15:0] b_h;
  logic [21:0] b_sn, b_ln;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (adv) begin
      b_vld <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_px <= d1_px;
      b_h  <= hadj;
      b_sn <= s_prod[21:0];
      b_ln <= l_prod[21:0];
    end
  end

  // Divide by a hundred through the reciprocal
  logic [44:0] s_rcp, l_rcp;

  assign s_rcp = 45'(b_sn) * 45'(PCT_RECIP);
  assign l_rcp = 45'(b_ln) * 45'(PCT_RECIP);

  // ---------------- scale stage: quotients ----------------
  logic        m_vld;
  logic [31:0] m_px;
  logic [15:0] m_h, m_s, m_l;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (adv) begin
      m_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_px <= b_px;
      m_h  <= b_h;
      m_s  <= s_rcp[PCT_SHIFT +: 16];
      m_l  <= l_rcp[PCT_SHIFT +: 16];
    end
  end

  // ---------------- product stage: L*S ----------------
  logic        c_vld;
  logic [31:0] c_px;
  logic [15:0] c_h, c_s, c_l;
  logic [31:0] c_ls;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (adv) begin
      c_vld <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_px <= m_px;
      c_h  <= m_h;
      c_s  <= m_s;
      c_l  <= m_l;
      c_ls <= 32'(m_s) * 32'(m_l);
    end
  end

  // Form q and p, place the three channels on the hue circle
  logic [31:0]        ls_rnd;
  logic signed [18:0] qv, pv, lv, sv, lsr;
  logic [15:0]        t_r, t_b;
  chan_w_t            cw_r, cw_g, cw_b;

  always_comb begin
    ls_rnd = c_ls + 32'(Q_HALF);
    lsr = $signed({1'b0, ls_rnd[31:14]});
    lv  = $signed({3'b0, c_l});
    sv  = $signed({3'b0, c_s});
    if ({1'b0, c_l, 1'b0} < 18'(Q_ONE)) begin
      qv = lv + lsr;
    end else begin
      qv = lv + sv - lsr;
    end
    pv = (lv <<< 1) - qv;
    t_r = (c_h >= 16'(HUE_FULL - HUE_THIRD)) ? c_h - 16'(HUE_FULL - HUE_THIRD)
                                             : c_h + 16'(HUE_THIRD);
    t_b = (c_h < 16'(HUE_THIRD)) ? c_h + 16'(HUE_FULL - HUE_THIRD)
                                 : c_h - 16'(HUE_THIRD);
    cw_r = chan_weight(t_r);
    cw_g = chan_weight(c_h);
    cw_b = chan_weight(t_b);
  end

  logic               e0_vld;
  logic [31:0]        e0_px;
  logic signed [18:0] e0_q, e0_p;
  chan_w_t [2:0]      e0_cw;

  always_ff @(posedge clk) begin
    if (rst) begin
      e0_vld <= 1'b0;
    end else if (adv) begin
      e0_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e0_px <= c_px;
      e0_q  <= qv;
      e0_p  <= pv;
      e0_cw <= {cw_b, cw_g, cw_r};
    end
  end

  // Interpolation products, floored by 512 and biased above zero
  logic signed [19:0] qp_diff;
  logic [2:0][22:0]   i_num;

  always_comb begin
    qp_diff = 20'(e0_q) - 20'(e0_p);
  end

  for (genvar c = 0; c < 3; c++) begin : g_interp
    logic signed [33:0] xp;
    logic signed [24:0] yv;
    assign xp = 34'(qp_diff) * $signed({21'b0, e0_cw[c].w}) + 34'sd3840;
    assign yv = 25'(xp >>> 9);
    assign i_num[c] = 23'(yv + 25'(INTERP_OFFSET));
  end

  // ---------------- interpolation stage ----------------
  logic               e1_vld;
  logic [31:0]        e1_px;
  logic signed [18:0] e1_q, e1_p;
  logic [2:0][1:0]    e1_seg;
  logic [2:0][22:0]   e1_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_vld <= 1'b0;
    end else if (adv) begin
      e1_vld <= e0_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_px  <= e0_px;
      e1_q   <= e0_q;
      e1_p   <= e0_p;
      e1_seg <= {e0_cw[2].seg, e0_cw[1].seg, e0_cw[0].seg};
      e1_num <= i_num;
    end
  end

  logic signed [18:0] f_lvl [3];

  // Divide by fifteen, drop the bias and pick the channel level
  for (genvar c = 0; c < 3; c++) begin : g_level
    logic [46:0]        rcp;
    logic signed [19:0] fq;
    assign rcp = 47'(e1_num[c]) * 47'(INTERP_RECIP);
    assign fq  = $signed(rcp[INTERP_SHIFT +: 20]) - $signed(20'(INTERP_BIAS));
    always_comb begin
      case (e1_seg[c])
        SEG_HIGH: f_lvl[c] = e1_q;
        SEG_LOW:  f_lvl[c] = e1_p;
        default:  f_lvl[c] = 19'(20'(e1_p) + fq);
      endcase
    end
  end

  // ---------------- level stage ----------------
  logic               g_vld;
  logic [31:0]        g_px;
  logic signed [18:0] g_lvl [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else if (adv) begin
      g_vld <= e1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_px  <= e1_px;
      g_lvl <= f_lvl;
    end
  end

  // Convert to bytes and clamp
  logic [2:0][7:0] g_byte;

  for (genvar c = 0; c < 3; c++) begin : g_tobyte
    logic signed [27:0] bp;
    logic signed [13:0] bv;
    assign bp = 28'(g_lvl[c]) * 28'sd255 + 28'(Q_HALF);
    assign bv = 14'(bp >>> 14);
    assign g_byte[c] = bv[13] ? 8'd0 :
                       (bv > 14'sd255) ? 8'(BYTE_MAX) : bv[7:0];
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= g_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_out <= neutral ? g_px : {g_px[31:24], g_byte[2], g_byte[1], g_byte[0]};
    end
  end

endmodule
